@@ design/set_assoc_tag_cache_tree_plru_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative tag cache
// Concurrent check macros clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_TAG_CACHE_TREE_PLRU_ASSERT_SVH
`define SET_ASSOC_TAG_CACHE_TREE_PLRU_ASSERT_SVH

// Plain property check, sampled on the rising clock edge.
`define SATC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication check built on the plain check.
`define SATC_ASSERT_IMPL(name, ante, cons, msg) \
  `SATC_ASSERT(name, (ante) |-> (cons), msg)

// Next-cycle implication check built on the plain check.
`define SATC_ASSERT_NEXT(name, ante, cons, msg) \
  `SATC_ASSERT(name, (ante) |=> (cons), msg)

`endif

@@ design/satc_pkg.sv @@
// ----------------------------------------------------------------------------
// Set-associative tag cache package
// Beat types, action codes, tree node codes and default geometry.
// ----------------------------------------------------------------------------
package satc_pkg;

  // Default geometry.
  localparam int unsigned DEF_SETS       = 64;
  localparam int unsigned DEF_WAYS       = 8;
  localparam int unsigned DEF_LINE_BYTES = 32;

  // Fixed field widths.
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WAY_OUT_W = 3;

  // Tree node codes: a node records the side the last touch went through.
  localparam logic [1:0] NODE_LEFT  = 2'd1;
  localparam logic [1:0] NODE_RIGHT = 2'd2;

  // Action carried by an input beat.
  typedef enum logic {
    ACT_ACCESS = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_e;

  // Input beat.
  typedef struct packed {
    action_e             action;
    logic [ADDR_W-1:0]   address;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 replaced;
  } out_t;

endpackage

@@ design/satc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module satc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ design/set_assoc_tag_cache_tree_plru.sv @@
// ----------------------------------------------------------------------------
// Set-associative tag cache with tree pseudo-LRU replacement
// Tag lookup, fill and victim selection over per-set RAM rows.
// ----------------------------------------------------------------------------
// An access beat is taken every cycle while no sweep runs and no lookup is held
// by a waiting result: it reads the tag, valid and tree rows of its set in the
// cycle it is accepted, is resolved from the registered RAM rows, written back
// and registered as a result, with the row forwarded when the next beat hits
// the same set. A flush beat gives its result and then clears the valid RAM
// one set per cycle; no beat is taken while the flush waits in the lookup
// stage or the sweep runs. After reset the valid and tree RAMs are cleared the
// same way before the first beat is taken. The result register lets a new beat
// enter while an earlier result waits.

`include "set_assoc_tag_cache_tree_plru_assert.svh"

module set_assoc_tag_cache_tree_plru #(
  parameter int unsigned SETS       = satc_pkg::DEF_SETS,
  parameter int unsigned WAYS       = satc_pkg::DEF_WAYS,
  parameter int unsigned LINE_BYTES = satc_pkg::DEF_LINE_BYTES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  satc_pkg::in_t  in_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output satc_pkg::out_t out_data_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  localparam int unsigned AW       = satc_pkg::ADDR_W;
  localparam int unsigned LB_W     = $clog2(LINE_BYTES);
  localparam int unsigned SET_W    = $clog2(SETS);
  localparam int unsigned SET_AW   = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned TAG_W    = AW - LB_W - SET_W;
  localparam int unsigned WAY_W    = $clog2(WAYS);
  localparam int unsigned TREE_W   = 2 * (WAYS - 1);
  localparam int unsigned TAGROW_W = WAYS * TAG_W;

  typedef logic [WAYS-1:0]             valid_row_t;
  typedef logic [WAYS-1:1][1:0]        tree_row_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;

  // Point every node on the path of a way toward it.
  function automatic tree_row_t tree_touch(tree_row_t t, logic [WAY_W-1:0] w);
    tree_row_t        r;
    logic [WAY_W:0]   leaf;
    logic [WAY_W-1:0] node;
    r    = t;
    leaf = {1'b1, w};
    for (int l = 0; l < WAY_W; l++) begin
      node    = WAY_W'(leaf >> (WAY_W - l));
      r[node] = w[WAY_W-1-l] ? satc_pkg::NODE_RIGHT : satc_pkg::NODE_LEFT;
    end
    return r;
  endfunction

  // Beat handshakes.
  logic accept;
  logic adv;
  logic wr_acc;

  // Address split of the incoming beat.
  logic [SET_AW-1:0] in_set;
  logic [TAG_W-1:0]  in_tag;

  // Lookup stage.
  logic              s1_valid_q;
  logic              s1_flush_q;
  logic [SET_AW-1:0] s1_set_q;
  logic [TAG_W-1:0]  s1_tag_q;

  // Forwarding of the last written rows.
  logic       fwd_sel_q;
  valid_row_t fwd_valid_q;
  tree_row_t  fwd_tree_q;
  tag_row_t   fwd_tags_q;

  // Clearing sweep.
  logic              clr_busy_q, clr_busy_d;
  logic              clr_tree_q, clr_tree_d;
  logic [SET_AW-1:0] clr_idx_q, clr_idx_d;
  logic              clr_last;

  // Result register.
  logic           out_valid_q, out_valid_d;
  satc_pkg::out_t out_q, out_d;

  // RAM rows.
  logic [WAYS-1:0]     vr_rdata;
  logic [TREE_W-1:0]   tr_rdata;
  logic [TAGROW_W-1:0] tg_rdata;
  valid_row_t          cur_valid, new_valid;
  tree_row_t           cur_tree, new_tree;
  tag_row_t            cur_tags, new_tags;
  logic [SET_AW-1:0]   wr_addr;

  // Lookup results.
  logic             hit;
  logic             repl;
  logic [WAY_W-1:0] new_way;

  // Handshakes and address split.
  assign accept     = in_valid_i && in_ready_o;
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign wr_acc     = adv && !s1_flush_q;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || (adv && !s1_flush_q));
  assign in_set     = SET_AW'((in_data_i.address >> LB_W) & AW'(SETS - 1));
  assign in_tag     = TAG_W'(in_data_i.address >> (LB_W + SET_W));

  // Row selection between RAM data and the forwarded write.
  assign cur_valid = fwd_sel_q ? fwd_valid_q : vr_rdata;
  assign cur_tree  = fwd_sel_q ? fwd_tree_q  : tree_row_t'(tr_rdata);
  assign cur_tags  = fwd_sel_q ? fwd_tags_q  : tag_row_t'(tg_rdata);

  // Tag compare, fill or victim choice, and the rows to write back.
  always_comb begin
    logic [WAYS-1:0]  match;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W:0]   node;
    tree_row_t        walk_tree;
    logic             full;

    match   = '0;
    hit_way = '0;
    inv_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = cur_valid[i] && (cur_tags[i] == s1_tag_q);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
      if (!cur_valid[i]) begin
        inv_way = WAY_W'(i);
      end
    end
    hit  = |match;
    full = &cur_valid;

    // Victim walk from the root, flipping each node on the way down.
    walk_tree = cur_tree;
    node      = (WAY_W + 1)'(1);
    for (int l = 0; l < WAY_W; l++) begin
      if (walk_tree[node[WAY_W-1:0]] == satc_pkg::NODE_LEFT) begin
        walk_tree[node[WAY_W-1:0]] = satc_pkg::NODE_RIGHT;
        node = {node[WAY_W-1:0], 1'b1};
      end else begin
        walk_tree[node[WAY_W-1:0]] = satc_pkg::NODE_LEFT;
        node = {node[WAY_W-1:0], 1'b0};
      end
    end

    new_valid = cur_valid;
    new_tags  = cur_tags;
    repl      = 1'b0;
    priority if (hit) begin
      new_way  = hit_way;
      new_tree = tree_touch(cur_tree, hit_way);
    end else if (full) begin
      new_way           = node[WAY_W-1:0];
      new_tree          = walk_tree;
      new_tags[new_way] = s1_tag_q;
      repl              = 1'b1;
    end else begin
      new_way            = inv_way;
      new_valid[inv_way] = 1'b1;
      new_tags[inv_way]  = s1_tag_q;
      new_tree           = tree_touch(cur_tree, inv_way);
    end
  end

  // Result beat; a flush reports all zeros.
  always_comb begin
    out_d = '0;
    if (!s1_flush_q) begin
      out_d.hit      = hit;
      out_d.way      = satc_pkg::WAY_OUT_W'(new_way);
      out_d.replaced = repl;
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Clearing sweep after reset (valid and tree) and after a flush (valid only).
  assign clr_last = (clr_idx_q == SET_AW'(SETS - 1));

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_tree_d = clr_tree_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_last ? '0 : clr_idx_q + SET_AW'(1);
      if (clr_last) begin
        clr_busy_d = 1'b0;
        clr_tree_d = 1'b0;
      end
    end else if (adv && s1_flush_q) begin
      clr_busy_d = 1'b1;
      clr_idx_d  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_tree_q  <= 1'b1;
      clr_idx_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      clr_busy_q  <= clr_busy_d;
      clr_tree_q  <= clr_tree_d;
      clr_idx_q   <= clr_idx_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_sel_q  <= wr_acc && (in_set == s1_set_q);
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q <= (in_data_i.action == satc_pkg::ACT_FLUSH);
      s1_set_q   <= in_set;
      s1_tag_q   <= in_tag;
    end
    if (wr_acc) begin
      fwd_valid_q <= new_valid;
      fwd_tree_q  <= new_tree;
      fwd_tags_q  <= new_tags;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Per-set RAMs: valid bits, tree nodes and tags.
  assign wr_addr = clr_busy_q ? clr_idx_q : s1_set_q;

  satc_ram #(
    .WIDTH (WAYS),
    .DEPTH (SETS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (wr_acc || clr_busy_q),
    .waddr_i (wr_addr),
    .wdata_i (clr_busy_q ? '0 : new_valid),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (vr_rdata)
  );

  satc_ram #(
    .WIDTH (TREE_W),
    .DEPTH (SETS)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (wr_acc || (clr_busy_q && clr_tree_q)),
    .waddr_i (wr_addr),
    .wdata_i (clr_busy_q ? '0 : TREE_W'(new_tree)),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (tr_rdata)
  );

  satc_ram #(
    .WIDTH (TAGROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_acc),
    .waddr_i (s1_set_q),
    .wdata_i (TAGROW_W'(new_tags)),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (tg_rdata)
  );

  // The sweep and a lookup write-back never share the RAM write port.
  `SATC_ASSERT(a_no_wr_clash, !(clr_busy_q && wr_acc), "sweep and write-back collide")
  // A lookup held by a stalled result keeps its set until it moves on.
  `SATC_ASSERT_NEXT(a_s1_hold, s1_valid_q && out_valid_q && !out_ready_i,
                    s1_valid_q && $stable(s1_set_q), "stalled lookup lost its set")
  // A sweep started by a flush comes with an all-zero result beat.
  `SATC_ASSERT_IMPL(a_flush_zero, $rose(clr_busy_q),
                    out_valid_o && !out_data_o.hit && (out_data_o.way == '0) &&
                    !out_data_o.replaced, "flush result not zero")

endmodule
